FILE: rtl/pfau_pkg.sv
// shared types and constants for the prime field arithmetic unit
package pfau_pkg;
    localparam int DEFAULT_WIDTH = 64;
    localparam int EXP_WIDTH = 63;

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_NEG = 3'd3;
    localparam logic [2:0] CMD_POW = 3'd4;

    // datapath operations chosen by the controller
    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_LOAD   = 3'd1,
        OP_REDA   = 3'd2,
        OP_REDB   = 3'd3,
        OP_MULRB  = 3'd4,
        OP_MULBB  = 3'd5,
        OP_MULAB  = 3'd6,
        OP_FINISH = 3'd7
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic       start;
    } dp_cmd_t;

    typedef struct packed {
        logic       busy;
        logic       p_small;
        logic       e_zero;
        logic       e_lsb;
        logic       e_next_zero;
        logic [2:0] command;
    } dp_status_t;
endpackage

FILE: rtl/pfau_datapath.sv
// datapath: operand registers, bit-serial reducer and shift-add modular multiplier
module pfau_datapath
    import pfau_pkg::*;
#(
    parameter int WIDTH = DEFAULT_WIDTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [WIDTH-1:0]     p,
    input  logic [2:0]           in_command,
    input  logic [WIDTH-1:0]     in_lhs,
    input  logic [WIDTH-1:0]     in_rhs,
    input  logic [EXP_WIDTH-1:0] in_exponent,
    input  dp_cmd_t              cmd,
    output dp_status_t           status,
    output logic [WIDTH-1:0]     result
);
    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0]     a_reg, b_reg, r_reg, x_reg, y_reg, acc_reg, src_reg;
    logic [WIDTH-1:0]     a_next, b_next, r_next, x_next, y_next, acc_next, src_next;
    logic [EXP_WIDTH-1:0] e_reg, e_next;
    logic [2:0]           c_reg, c_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic [1:0]           mode_reg, mode_next;   // 0 reduce, 1 multiply
    logic [1:0]           dst_reg, dst_next;     // 0 a, 1 b, 2 r
    logic [WIDTH-1:0]     res_reg, res_next;

    // (s + t) mod p for s, t < p
    function automatic logic [WIDTH-1:0] addm(input logic [WIDTH-1:0] s,
                                              input logic [WIDTH-1:0] t,
                                              input logic [WIDTH-1:0] m);
        logic [WIDTH:0] sum;
        sum = {1'b0, s} + {1'b0, t};
        if (sum >= {1'b0, m})
            sum = sum - {1'b0, m};
        return sum[WIDTH-1:0];
    endfunction

    logic [WIDTH-1:0] step_val;
    logic [WIDTH-1:0] dbl;
    logic [WIDTH-1:0] one_val;

    assign one_val = {{(WIDTH-1){1'b0}}, 1'b1};
    assign dbl = addm(acc_reg, acc_reg, p);

    always_comb
    begin
        // reduce: acc = 2*acc + bit mod p; multiply: acc = 2*acc + (bit ? x : 0)
        if (mode_reg == 2'd0)
            step_val = addm(dbl, src_reg[WIDTH-1] ? one_val : '0, p);
        else
            step_val = addm(dbl, y_reg[WIDTH-1] ? x_reg : '0, p);
    end

    always_comb
    begin
        logic [WIDTH-1:0] sa, sb, sub_v, neg_v, add_v;
        a_next = a_reg; b_next = b_reg; r_next = r_reg; x_next = x_reg;
        y_next = y_reg; acc_next = acc_reg; src_next = src_reg; e_next = e_reg;
        c_next = c_reg; cnt_next = cnt_reg; busy_next = busy_reg;
        mode_next = mode_reg; dst_next = dst_reg; res_next = res_reg;
        sa = a_reg; sb = b_reg;
        sub_v = (sa >= sb) ? sa - sb : sa + (p - sb);
        neg_v = (sa == '0) ? '0 : p - sa;
        add_v = addm(sa, sb, p);
        if (busy_reg) begin
            acc_next = step_val;
            src_next = src_reg << 1;
            y_next = y_reg << 1;
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                case (dst_reg)
                    2'd0: a_next = step_val;
                    2'd1: b_next = step_val;
                    default: r_next = step_val;
                endcase
            end
        end else if (cmd.start) begin
            case (cmd.op)
                OP_LOAD: begin
                    // power keeps its base in b
                    a_next = in_lhs;
                    b_next = (in_command == CMD_POW) ? in_lhs : in_rhs;
                    e_next = in_exponent;
                    c_next = in_command;
                end
                OP_REDA, OP_REDB: begin
                    src_next = (cmd.op == OP_REDA) ? a_reg : b_reg;
                    dst_next = (cmd.op == OP_REDA) ? 2'd0 : 2'd1;
                    mode_next = 2'd0; acc_next = '0;
                    cnt_next = CW'(WIDTH); busy_next = 1'b1;
                    if (cmd.op == OP_REDA)
                        r_next = (p > one_val) ? one_val : '0;
                end
                OP_MULRB, OP_MULBB, OP_MULAB: begin
                    mode_next = 2'd1; acc_next = '0;
                    cnt_next = CW'(WIDTH); busy_next = 1'b1;
                    x_next = (cmd.op == OP_MULRB) ? r_reg : a_reg;
                    y_next = b_reg;
                    dst_next = (cmd.op == OP_MULBB) ? 2'd1 : 2'd2;
                    if (cmd.op == OP_MULRB) e_next = e_reg >> 1;
                end
                OP_FINISH: begin
                    if (p <= one_val) res_next = '0;
                    else begin
                        case (c_reg)
                            CMD_ADD: res_next = add_v;
                            CMD_SUB: res_next = sub_v;
                            CMD_MUL: res_next = r_reg;
                            CMD_NEG: res_next = neg_v;
                            CMD_POW: res_next = r_reg;
                            default: res_next = '0;
                        endcase
                    end
                end
                default: ;
            endcase
        end
        // multiply for pow uses base in b: r*b, and b*b
        if (!busy_reg && cmd.start && cmd.op == OP_MULRB) x_next = r_reg;
        if (!busy_reg && cmd.start && cmd.op == OP_MULBB) x_next = b_reg;
        if (!busy_reg && cmd.start && cmd.op == OP_MULAB) begin
            x_next = a_reg; y_next = b_reg;
        end
        if (!busy_reg && cmd.start && cmd.op == OP_MULBB) e_next = e_reg >> 1;
        if (!busy_reg && cmd.start && cmd.op == OP_MULRB) e_next = e_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next; b_reg <= b_next; r_reg <= r_next; x_reg <= x_next;
        y_reg <= y_next; acc_reg <= acc_next; src_reg <= src_next; e_reg <= e_next;
        c_reg <= c_next; mode_reg <= mode_next; dst_reg <= dst_next;
        res_reg <= res_next;
    end

    assign status.busy        = busy_reg;
    assign status.p_small     = (p <= one_val);
    assign status.e_zero      = (e_reg == '0);
    assign status.e_lsb       = e_reg[0];
    assign status.e_next_zero = ((e_reg >> 1) == '0);
    assign status.command     = c_reg;
    assign result = res_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg != '0))
        else $error("busy with zero count");
    assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && cnt_reg == CW'(1)) |=> !busy_reg)
        else $error("operation did not end");
    assert property (@(posedge clk) disable iff (!rst_n)
        (!busy_reg && cmd.start && cmd.op == OP_REDA) |=> busy_reg)
        else $error("reduce did not start");
endmodule

FILE: rtl/pfau_controller.sv
// controller state machine sequencing reduce, multiply and power steps
module pfau_controller
    import pfau_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_REDA  = 10'b0000000010,
        S_REDB  = 10'b0000000100,
        S_DISP  = 10'b0000001000,
        S_MUL   = 10'b0000010000,
        S_PCHK  = 10'b0000100000,
        S_PMUL  = 10'b0001000000,
        S_PSQ   = 10'b0010000000,
        S_FIN   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   issued_reg, issued_next;

    always_comb
    begin
        state_next = state_reg;
        issued_next = issued_reg;
        cmd.op = OP_NONE;
        cmd.start = 1'b0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                cmd.op = OP_LOAD;
                cmd.start = in_valid;
                if (in_valid) state_next = S_REDA;
            end
            S_REDA, S_REDB, S_MUL, S_PMUL, S_PSQ: begin
                if (!issued_reg) begin
                    cmd.start = 1'b1;
                    case (state_reg)
                        S_REDA: cmd.op = OP_REDA;
                        S_REDB: cmd.op = OP_REDB;
                        S_MUL:  cmd.op = OP_MULAB;
                        S_PMUL: cmd.op = OP_MULRB;
                        default: cmd.op = OP_MULBB;
                    endcase
                    issued_next = 1'b1;
                end else if (!status.busy) begin
                    issued_next = 1'b0;
                    case (state_reg)
                        S_REDA: state_next = S_REDB;
                        S_REDB: state_next = S_DISP;
                        S_MUL:  state_next = S_FIN;
                        S_PMUL: state_next = status.e_next_zero ? S_FIN : S_PSQ;
                        default: state_next = S_PCHK;
                    endcase
                end
            end
            S_DISP: begin
                if (status.p_small) state_next = S_FIN;
                else if (status.command == CMD_MUL) state_next = S_MUL;
                else if (status.command == CMD_POW) state_next = S_PCHK;
                else state_next = S_FIN;
            end
            S_PCHK: begin
                // base squared into b; exponent shifted after each square
                if (status.e_zero) state_next = S_FIN;
                else if (status.e_lsb) state_next = S_PMUL;
                else if (status.e_next_zero) state_next = S_FIN;
                else state_next = S_PSQ;
            end
            S_FIN: begin
                cmd.op = OP_FINISH;
                cmd.start = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                out_valid = 1'b1;
                if (out_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            issued_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            issued_reg <= issued_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state not one-hot");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped");
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("accepting while result pending");
endmodule

FILE: rtl/prime_field_arithmetic_unit.sv
// top level of the prime field arithmetic unit
// One request at a time. Operands are reduced bit-serially, and multiplies use a
// shift-add reducing multiplier. A power runs up to 125 multiplies and squares for a
// 63-bit exponent. A result waits in the output register until taken; the next
// request is taken after that. Only the low OPERAND_WIDTH bits of modulus and
// operands are used; a modulus below two gives zero for every command, and unknown
// commands give zero.
module prime_field_arithmetic_unit
    import pfau_pkg::*;
#(
    parameter int OPERAND_WIDTH = DEFAULT_WIDTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [63:0]   cfg_wdata,     // modulus
    input  logic          s_tvalid,
    output logic          s_tready,
    // command [2:0], lhs [66:3], rhs [130:67], exponent [193:131], zero fill
    input  logic [199:0]  s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [63:0]   m_tdata        // result
);
    logic [63:0] modulus_reg;
    dp_cmd_t     cmd;
    dp_status_t  status;
    logic [OPERAND_WIDTH-1:0] res_w;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            modulus_reg <= 64'd2;
        else if (cfg_we)
            modulus_reg <= cfg_wdata;
    end

    pfau_controller u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .status(status), .cmd(cmd)
    );

    pfau_datapath #(.WIDTH(OPERAND_WIDTH)) u_dp (
        .clk(clk), .rst_n(rst_n),
        .p(modulus_reg[OPERAND_WIDTH-1:0]),
        .in_command(s_tdata[2:0]),
        .in_lhs(s_tdata[3 +: OPERAND_WIDTH]),
        .in_rhs(s_tdata[67 +: OPERAND_WIDTH]),
        .in_exponent(s_tdata[193:131]),
        .cmd(cmd), .status(status), .result(res_w)
    );

    // zero-extend result to the port
    assign m_tdata = 64'(res_w);
endmodule

FILE: tb/sv/tb_prime_field_arithmetic_unit.sv
// testbench for the prime field arithmetic unit: random and directed requests checked against a predictor
`timescale 1ns / 1ps
module tb_prime_field_arithmetic_unit;
    import pfau_pkg::*;

    logic          clk;
    logic          rst_n;
    logic          cfg_we;
    logic [63:0]   cfg_wdata;
    logic          s_tvalid;
    logic          s_tready;
    logic [199:0]  s_tdata;
    logic          m_tvalid;
    logic          m_tready;
    logic [63:0]   m_tdata;

    // field modulus as the predictor sees it
    logic [63:0]   field_mod;
    logic [63:0]   expected_results[$];
    int            error_count;
    bit            hold_off;
    bit            burst_on;

    prime_field_arithmetic_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // modular addition of two reduced values, with the carry kept
    function automatic logic [63:0] field_add(logic [63:0] a, logic [63:0] b, logic [63:0] p);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, p})
            s = s - {1'b0, p};
        return s[63:0];
    endfunction

    function automatic logic [63:0] field_sub(logic [63:0] a, logic [63:0] b, logic [63:0] p);
        if (a >= b)
            return a - b;
        return a + (p - b);
    endfunction

    function automatic logic [63:0] field_mul(logic [63:0] a, logic [63:0] b, logic [63:0] p);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return 64'(prod % {64'd0, p});
    endfunction

    // square-and-multiply from the low exponent bit up
    function automatic logic [63:0] field_pow(logic [63:0] b, logic [62:0] e, logic [63:0] p);
        logic [63:0] acc;
        acc = 64'd1;
        while (e != 0)
        begin
            if (e[0])
                acc = field_mul(acc, b, p);
            b = field_mul(b, b, p);
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic logic [63:0] predict_result(logic [2:0] cmd, logic [63:0] lhs,
                                                   logic [63:0] rhs, logic [62:0] e);
        logic [63:0] a;
        logic [63:0] b;
        if (field_mod < 64'd2)
            return 64'd0;
        a = lhs % field_mod;
        b = rhs % field_mod;
        case (cmd)
            CMD_ADD: return field_add(a, b, field_mod);
            CMD_SUB: return field_sub(a, b, field_mod);
            CMD_MUL: return field_mul(a, b, field_mod);
            CMD_NEG: return field_sub(64'd0, a, field_mod);
            CMD_POW: return field_pow(a, e, field_mod);
            default: return 64'd0;
        endcase
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // send one request, honoring the burst pattern
    task automatic send_request(logic [2:0] cmd, logic [63:0] lhs, logic [63:0] rhs,
                                logic [62:0] e);
        int gap;
        if (!burst_on)
        begin
            gap = $urandom_range(0, 5);
            repeat (gap) @(negedge clk);
            burst_on = ($urandom_range(0, 3) != 0);
        end
        else if ($urandom_range(0, 7) == 0)
            burst_on = 1'b0;
        s_tdata  = {6'd0, e, rhs, lhs, cmd};
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_results.push_back(predict_result(cmd, lhs, rhs, e));
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    // wait for all results, then let the block settle before a register write
    task automatic drain_results();
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_modulus(logic [63:0] value);
        drain_results();
        cfg_wdata = value;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we    = 1'b0;
        field_mod = value;
    endtask

    task automatic random_request(int max_exp_bits);
        logic [62:0] e;
        logic [2:0]  cmd;
        cmd = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                           : 3'($urandom_range(0, 4));
        e = 63'({$urandom, $urandom});
        e = e >> (63 - $urandom_range(0, max_exp_bits));
        send_request(cmd, rand64(), rand64(), e);
    endtask

    // edge operands, add and power at the reset modulus, and every command at a large prime
    task automatic test_directed();
        logic [63:0] all_ones;
        all_ones = '1;
        send_request(CMD_ADD, all_ones, all_ones, 63'd5);
        send_request(CMD_POW, 64'd3, 64'd0, 63'd7);
        write_modulus(64'hFFFF_FFFF_FFFF_FFC5);
        send_request(CMD_ADD, all_ones, all_ones, '0);
        send_request(CMD_ADD, 64'hFFFF_FFFF_FFFF_FFC4, 64'd1, '0);
        send_request(CMD_SUB, 64'd0, all_ones, '0);
        send_request(CMD_SUB, all_ones, 64'd0, '0);
        send_request(CMD_MUL, all_ones, 64'hFFFF_FFFF_FFFF_FFC4, '0);
        send_request(CMD_NEG, 64'd0, all_ones, '0);
        send_request(CMD_NEG, 64'd1, 64'd0, '0);
        send_request(CMD_POW, 64'd12345, 64'd0, 63'd0);
        send_request(CMD_POW, all_ones, 64'd0, 63'd1);
        send_request(CMD_POW, 64'd7, all_ones, '1);
        send_request(CMD_POW, 64'd0, 64'd0, 63'd9);
        send_request(3'd5, 64'd3, 64'd4, '1);
        send_request(3'd6, all_ones, 64'd4, '0);
        send_request(3'd7, 64'd9, all_ones, '0);
    endtask

    // modulus below two (zero and one) gives zero, checked with add, negate and power
    task automatic test_small_modulus();
        write_modulus(64'd0);
        send_request(CMD_ADD, 64'd5, 64'd6, '0);
        send_request(CMD_POW, 64'd5, 64'd6, 63'd0);
        write_modulus(64'd1);
        send_request(CMD_NEG, 64'd5, 64'd6, '0);
        send_request(CMD_POW, 64'd5, 64'd6, 63'd3);
    endtask

    // random requests over several moduli, a composite one among them
    task automatic test_random();
        write_modulus('1);
        repeat (25) random_request(62);
        write_modulus(64'd1_000_000_007);
        repeat (25) random_request(20);
        write_modulus(64'd221);
        repeat (20) random_request(12);
        write_modulus(64'd3);
        repeat (15) random_request(8);
    endtask

    // long output stall while requests keep coming so the input backs up
    task automatic test_backpressure();
        write_modulus(64'd97);
        hold_off = 1'b1;
        repeat (6) send_request(CMD_ADD, rand64(), rand64(), '0);
        hold_off = 1'b0;
        drain_results();
    endtask

    // receiver stall pattern, with stall-free stretches and the long hold-off
    initial
    begin
        int phase;
        int stall_cycles;
        m_tready = 1'b0;
        phase = 0;
        stall_cycles = 0;
        forever
        begin
            @(negedge clk);
            phase++;
            if (hold_off && stall_cycles < 300)
            begin
                stall_cycles++;
                m_tready = 1'b0;
            end
            else if ((phase / 64) % 3 == 0)
                m_tready = 1'b1;
            else
                m_tready = ($urandom_range(0, 2) != 0);
            if (!hold_off)
                stall_cycles = 0;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        logic [63:0] exp_result;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no request waiting: %h", m_tdata);
                error_count++;
            end
            else
            begin
                exp_result = expected_results.pop_front();
                if (m_tdata !== exp_result)
                begin
                    $error("result mismatch: expected %h actual %h", exp_result, m_tdata);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #6_000_000;
        $display("tb_prime_field_arithmetic_unit NOT OK");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        field_mod = 64'd2;
        error_count = 0;
        hold_off  = 1'b0;
        burst_on  = 1'b1;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_small_modulus();
        test_backpressure();
        test_random();

        drain_results();
        repeat (200) @(negedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("tb_prime_field_arithmetic_unit OK");
        else
            $display("tb_prime_field_arithmetic_unit NOT OK");
        $finish;
    end
endmodule

FILE: sim.f
rtl/pfau_pkg.sv
rtl/pfau_datapath.sv
rtl/pfau_controller.sv
rtl/prime_field_arithmetic_unit.sv
tb/sv/tb_prime_field_arithmetic_unit.sv
